@@ rtl/core/key_chord_action_mapper_macros.svh @@
// Assertion macros for the key chord action mapper.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef KEY_CHORD_ACTION_MAPPER_MACROS_SVH
`define KEY_CHORD_ACTION_MAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// a must hold at every clock edge outside reset
`define KCAM_ASSERT(lbl, a, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a)) else $error(msg);

// a implies b in the same cycle
`define KCAM_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define KCAM_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`else

`define KCAM_ASSERT(lbl, a, msg)
`define KCAM_ASSERT_IMP(lbl, a, b, msg)
`define KCAM_ASSERT_NXT(lbl, a, b, msg)

`endif

`endif

@@ rtl/core/kcam_pkg.sv @@
// Types and constants shared by the key chord action mapper modules.
// No dependencies.
package kcam_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_CLOSE
  } kcam_state_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } kcam_op_e;

  localparam int unsigned RAW_KEY_W   = 24;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned KEY_CNT_W   = 4;
  localparam int unsigned CHORD_SLOTS = 4;

  localparam logic [KEY_CNT_W-1:0] PROFILE_COUNT = 4'd4;
  localparam logic [7:0] PROFILE_KEY_A = 8'd16;
  localparam logic [7:0] PROFILE_KEY_B = 8'd17;
  localparam logic [7:0] PROFILE_KEY_C = 8'd18;

  localparam logic [7:0]  MODE_EVERY      = 8'd0;
  localparam logic [7:0]  MODE_ONCE       = 8'd1;
  localparam logic [7:0]  MODE_RELEASE    = 8'd2;
  localparam logic [7:0]  MODE_REPEAT_MIN = 8'd10;
  localparam logic [11:0] REPEAT_STEP_MS  = 12'd10;

  // register index decoded from paddr bit 2
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef struct packed {
    logic [7:0] k1;
    logic [7:0] k2;
    logic [7:0] k3;
    logic [7:0] modifier;
    logic [7:0] keycode;
    logic [7:0] mode;
  } kcam_def_t;

  typedef struct packed {
    logic [7:0] key0;
    logic [7:0] key1;
    logic [7:0] key2;
  } kcam_keys_t;

  typedef struct packed {
    logic       done;
    logic       too_many;
    logic       profile_req;
    logic [4:0] profile_num;
    kcam_keys_t keys;
  } kcam_scan_t;

  typedef struct packed {
    logic        emit;
    logic        fire;
    logic        set_flag;
    logic        clr_flag;
    logic        dl_we;
    logic [31:0] dl_new;
  } kcam_eval_t;

  typedef struct packed {
    logic [4:0] profile_number;
    logic       profile_request_valid;
    logic       too_many_keys;
    logic       release_all;
    logic [7:0] key_code;
    logic [7:0] modifier_code;
    logic [4:0] entry_number;
    logic       action_valid;
  } kcam_result_t;

endpackage

@@ rtl/core/key_chord_action_mapper.sv @@
// Key chord action mapper: writes load a definition, scans walk N entries one per cycle while
// the output register can take each emitted result. A write closes via ST_CLOSE and the output
// register; a scan collects keys (ST_SCAN), walks entries (ST_WALK) and closes (ST_CLOSE), or
// closes at once if aborted. One item at a time, the next accepted when the closing result is
// loaded; paced by the one-key-per-cycle collector, the shared entry unit and output stalls.
// Reset clears control, pressed flags and deadline valid bits, not the definition table.
`include "key_chord_action_mapper_macros.svh"

module key_chord_action_mapper #(
  parameter int unsigned TABLE_ENTRIES  = 32,
  parameter int unsigned MAX_CHORD_KEYS = 4,
  parameter int unsigned KEY_BITS       = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // entry_index[4:0] entry_first_key[12:5] entry_second_key[20:13]
  // entry_third_key[28:21] entry_modifier[36:29] entry_keycode[44:37]
  // entry_mode[52:45] raw_keys[76:53] now_ms[108:77], zero fill above
  input  logic [111:0] s_axis_tdata_i,
  // operation[0]
  input  logic [0:0]   s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // action_valid[0] entry_number[5:1] modifier_code[13:6] key_code[21:14]
  // release_all[22] too_many_keys[23] profile_request_valid[24]
  // profile_number[29:25], zero fill above
  output logic [31:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LW    = (CNT_W > kcam_pkg::CFG_W) ? CNT_W : kcam_pkg::CFG_W;

  kcam_pkg::kcam_state_e state_q, state_d;
  logic [LW-1:0]         idx_q, idx_d;
  logic [LW-1:0]         n_lim;
  logic [LW-1:0]         cfg_ext;
  logic [IDX_W-1:0]      idx_a;
  logic [IDX_W-1:0]      rd_addr;
  logic                  advance;

  logic [kcam_pkg::CFG_W-1:0] entries_q;

  kcam_pkg::kcam_keys_t  keys_q, keys_d;
  logic                  many_q, many_d;
  logic                  preq_q, preq_d;
  logic [4:0]            pnum_q, pnum_d;
  logic [31:0]           now_q;

  logic                  accept;
  logic                  scan_start;
  logic                  def_we;
  logic                  slot_ok;
  kcam_pkg::kcam_def_t   in_def;
  kcam_pkg::kcam_def_t   rd_def;
  kcam_pkg::kcam_scan_t  scan;
  kcam_pkg::kcam_eval_t  ev;

  logic [TABLE_ENTRIES-1:0] flag_q;
  logic [TABLE_ENTRIES-1:0] dl_vld_q;
  logic [31:0]              dl_mem [TABLE_ENTRIES];
  logic [31:0]              dl_rdata_q;
  logic [31:0]              deadline;

  logic                   out_free;
  logic                   out_load;
  logic                   out_last_d;
  kcam_pkg::kcam_result_t out_d;
  kcam_pkg::kcam_result_t out_q;
  logic                   out_last_q;
  logic                   out_valid_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == kcam_pkg::REG_ENTRIES_IN_USE) ? 32'(entries_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == kcam_pkg::REG_ENTRIES_IN_USE) begin
      entries_q <= pwdata[kcam_pkg::CFG_W-1:0];
    end
  end

  assign cfg_ext = LW'(entries_q);
  assign n_lim   = (cfg_ext > LW'(TABLE_ENTRIES)) ? LW'(TABLE_ENTRIES) : cfg_ext;

  // input unpacking
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == kcam_pkg::ST_IDLE);
  assign in_def.k1       = s_axis_tdata_i[12:5];
  assign in_def.k2       = s_axis_tdata_i[20:13];
  assign in_def.k3       = s_axis_tdata_i[28:21];
  assign in_def.modifier = s_axis_tdata_i[36:29];
  assign in_def.keycode  = s_axis_tdata_i[44:37];
  assign in_def.mode     = s_axis_tdata_i[52:45];
  assign slot_ok         = (8'(s_axis_tdata_i[4:0]) < 8'(TABLE_ENTRIES));

  kcam_def_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_def_ram (
    .clk_i   (clk_i),
    .we_i    (def_we),
    .waddr_i (IDX_W'(s_axis_tdata_i[4:0])),
    .wdata_i (in_def),
    .raddr_i (rd_addr),
    .rdata_o (rd_def)
  );

  kcam_key_scan #(
    .KEY_BITS       (KEY_BITS),
    .MAX_CHORD_KEYS (MAX_CHORD_KEYS)
  ) u_key_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .raw_keys_i (s_axis_tdata_i[76:53]),
    .scan_o     (scan)
  );

  assign idx_a    = idx_q[IDX_W-1:0];
  assign deadline = dl_vld_q[idx_a] ? dl_rdata_q : 32'd0;

  kcam_entry_eval u_entry_eval (
    .def_i      (rd_def),
    .keys_i     (keys_q),
    .flag_i     (flag_q[idx_a]),
    .deadline_i (deadline),
    .now_i      (now_q),
    .eval_o     (ev)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= s_axis_tdata_i[108:77];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    keys_d     = keys_q;
    many_d     = many_q;
    preq_d     = preq_q;
    pnum_d     = pnum_q;
    scan_start = 1'b0;
    def_we     = 1'b0;
    advance    = 1'b0;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    out_d      = '0;
    case (state_q)
      kcam_pkg::ST_IDLE: begin
        if (accept) begin
          many_d = 1'b0;
          preq_d = 1'b0;
          pnum_d = 5'd0;
          if (s_axis_tuser_i[0] == kcam_pkg::OP_WRITE) begin
            def_we  = slot_ok;
            state_d = kcam_pkg::ST_CLOSE;
          end else begin
            scan_start = 1'b1;
            state_d    = kcam_pkg::ST_SCAN;
          end
        end
      end
      kcam_pkg::ST_SCAN: begin
        if (scan.done) begin
          if (scan.too_many) begin
            many_d  = 1'b1;
            state_d = kcam_pkg::ST_CLOSE;
          end else begin
            keys_d  = scan.keys;
            preq_d  = scan.profile_req;
            pnum_d  = scan.profile_req ? scan.profile_num : 5'd0;
            idx_d   = '0;
            state_d = kcam_pkg::ST_WALK;
          end
        end
      end
      kcam_pkg::ST_WALK: begin
        if (idx_q >= n_lim) begin
          state_d = kcam_pkg::ST_CLOSE;
        end else if (ev.emit) begin
          if (out_free) begin
            out_load            = 1'b1;
            out_d.action_valid  = ev.fire;
            out_d.entry_number  = idx_q[4:0];
            out_d.modifier_code = rd_def.modifier;
            out_d.key_code      = rd_def.keycode;
            out_d.release_all   = 1'b1;
            advance             = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          idx_d = LW'(idx_q + 1'b1);
        end
      end
      kcam_pkg::ST_CLOSE: begin
        if (out_free) begin
          out_load                    = 1'b1;
          out_last_d                  = 1'b1;
          out_d.too_many_keys         = many_q;
          out_d.profile_request_valid = preq_q;
          out_d.profile_number        = pnum_q;
          state_d                     = kcam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kcam_pkg::ST_IDLE;
      end
    endcase
  end

  // read address runs one step ahead so read data matches idx_q
  always_comb begin
    if (state_q == kcam_pkg::ST_WALK) begin
      rd_addr = advance ? IDX_W'(idx_q + 1'b1) : idx_a;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kcam_pkg::ST_IDLE;
      idx_q    <= '0;
      many_q   <= 1'b0;
      preq_q   <= 1'b0;
      flag_q   <= '0;
      dl_vld_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      many_q  <= many_d;
      preq_q  <= preq_d;
      if (advance) begin
        if (ev.set_flag) begin
          flag_q[idx_a] <= 1'b1;
        end else if (ev.clr_flag) begin
          flag_q[idx_a] <= 1'b0;
        end
        if (ev.dl_we) begin
          dl_vld_q[idx_a] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q <= keys_d;
    pnum_q <= pnum_d;
  end

  // repeat deadline memory
  always_ff @(posedge clk_i) begin
    if (advance && ev.dl_we) begin
      dl_mem[idx_a] <= ev.dl_new;
    end
    dl_rdata_q <= dl_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

  `KCAM_ASSERT_NXT(a_busy_after_accept, accept, state_q != kcam_pkg::ST_IDLE, "accepted item left block idle")
  `KCAM_ASSERT_IMP(a_walk_in_range, state_q == kcam_pkg::ST_WALK, idx_q <= n_lim, "entry walk ran past search limit")
  `KCAM_ASSERT_IMP(a_many_is_last, m_axis_tvalid_o && m_axis_tdata_o[23], m_axis_tlast_o, "too_many_keys on a non-closing result")
  `KCAM_ASSERT_IMP(a_scan_done_state, scan.done, state_q == kcam_pkg::ST_SCAN, "key collector finished outside scan state")

endmodule

@@ rtl/core/kcam_def_ram.sv @@
// Definition table: one write port, one registered read port.
// Uses kcam_pkg for the definition layout.
module kcam_def_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  kcam_pkg::kcam_def_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output kcam_pkg::kcam_def_t rdata_o
);

  kcam_pkg::kcam_def_t mem [DEPTH];
  kcam_pkg::kcam_def_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/kcam_key_scan.sv @@
// Key collector: strips one pressed key per cycle off the key word.
// Uses kcam_pkg for the scan status struct.
module kcam_key_scan #(
  parameter int unsigned KEY_BITS       = 24,
  parameter int unsigned MAX_CHORD_KEYS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [kcam_pkg::RAW_KEY_W-1:0]     raw_keys_i,
  output kcam_pkg::kcam_scan_t               scan_o
);

  localparam int unsigned PW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  logic [31:0]         keys_ext;
  logic [KEY_BITS-1:0] pressed;
  logic [KEY_BITS-1:0] iso;
  logic [PW-1:0]       pos;

  logic                                busy_q;
  logic                                done_q;
  logic                                many_q;
  logic [KEY_BITS-1:0]                 pend_q;
  logic [kcam_pkg::KEY_CNT_W-1:0]      cnt_q;
  logic [7:0]                          buf_q [kcam_pkg::CHORD_SLOTS];

  // bytes 0 and 2 swapped; bits above the word read as pressed
  always_comb begin
    keys_ext = {8'h00, raw_keys_i[7:0], raw_keys_i[15:8], raw_keys_i[23:16]};
    for (int i = 0; i < KEY_BITS; i++) begin
      pressed[i] = ~keys_ext[i];
    end
  end

  assign iso = pend_q & (~pend_q + KEY_BITS'(1));

  always_comb begin
    pos = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (iso[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      many_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        many_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (pend_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (cnt_q == kcam_pkg::KEY_CNT_W'(MAX_CHORD_KEYS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          many_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pend_q <= pressed;
      for (int s = 0; s < kcam_pkg::CHORD_SLOTS; s++) begin
        buf_q[s] <= 8'd0;
      end
    end else if (busy_q && pend_q != '0 &&
                 cnt_q != kcam_pkg::KEY_CNT_W'(MAX_CHORD_KEYS)) begin
      pend_q <= pend_q & ~iso;
      if (cnt_q < kcam_pkg::KEY_CNT_W'(kcam_pkg::CHORD_SLOTS)) begin
        buf_q[cnt_q[1:0]] <= 8'(pos) + 8'd1;
      end
    end
  end

  always_comb begin
    scan_o.done        = done_q;
    scan_o.too_many    = many_q;
    scan_o.profile_req = (cnt_q == kcam_pkg::PROFILE_COUNT) &&
                         (buf_q[1] == kcam_pkg::PROFILE_KEY_A) &&
                         (buf_q[2] == kcam_pkg::PROFILE_KEY_B) &&
                         (buf_q[3] == kcam_pkg::PROFILE_KEY_C);
    scan_o.profile_num = buf_q[0][4:0];
    scan_o.keys.key0   = buf_q[0];
    scan_o.keys.key1   = buf_q[1];
    scan_o.keys.key2   = buf_q[2];
  end

endmodule

@@ rtl/core/kcam_entry_eval.sv @@
// Per-entry decision unit: chord compare, mode decode, deadline compare and add.
// Shared by every table entry in turn; uses kcam_pkg.
module kcam_entry_eval (
  input  kcam_pkg::kcam_def_t  def_i,
  input  kcam_pkg::kcam_keys_t keys_i,
  input  logic                 flag_i,
  input  logic [31:0]          deadline_i,
  input  logic [31:0]          now_i,
  output kcam_pkg::kcam_eval_t eval_o
);

  logic        empty;
  logic        match;
  logic [11:0] delay;

  assign empty = (keys_i.key0 == 8'd0);
  assign match = (def_i.k1 == keys_i.key0) && (def_i.k2 == keys_i.key1) &&
                 (def_i.k3 == keys_i.key2);
  assign delay = 12'(def_i.mode) * kcam_pkg::REPEAT_STEP_MS;

  always_comb begin
    eval_o        = '0;
    eval_o.dl_new = now_i + 32'(delay);
    if (empty) begin
      // release pass: fire pending on-release entries, clear every flag
      eval_o.emit     = (def_i.mode == kcam_pkg::MODE_RELEASE) && flag_i;
      eval_o.fire     = eval_o.emit;
      eval_o.clr_flag = 1'b1;
    end else if (match) begin
      eval_o.emit = 1'b1;
      if (def_i.mode == kcam_pkg::MODE_EVERY) begin
        eval_o.fire = 1'b1;
      end else if (def_i.mode == kcam_pkg::MODE_ONCE) begin
        eval_o.fire     = !flag_i;
        eval_o.set_flag = 1'b1;
      end else if (def_i.mode == kcam_pkg::MODE_RELEASE) begin
        eval_o.set_flag = 1'b1;
      end else if (def_i.mode >= kcam_pkg::MODE_REPEAT_MIN) begin
        if (deadline_i < now_i) begin
          eval_o.fire  = 1'b1;
          eval_o.dl_we = 1'b1;
        end
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for key_chord_action_mapper: loads chord definitions, sends
// key scans, and checks every result against an in-bench model of the mapper.
// Depends on kcam_pkg and the key_chord_action_mapper RTL.
module testbench;
  import kcam_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam logic [7:0] MODE_NEVER_FIRES = 8'd5;
  localparam logic [7:0] MODE_REPEAT_MAX = 8'd255;
  localparam logic [7:0] KEY_MOUSE_MOVE = 8'd170;

  typedef struct {
    kcam_op_e    op;
    logic [4:0]  slot;
    logic [7:0]  k1, k2, k3, mdf, kc, mode;
    logic [23:0] raw;
    logic [31:0] now;
  } key_item_t;

  typedef struct {
    kcam_result_t res;
    logic         last;
  } report_t;

  typedef struct {
    key_item_t  it;
    bit         typed;
    bit         many, preq;
    logic [4:0] pnum;
    int         in_use;
  } plan_row_t;

  logic         clk_i, rst_ni;
  logic [111:0] s_axis_tdata_i;
  logic [0:0]   s_axis_tuser_i;
  logic         s_axis_tvalid_i, s_axis_tready_o;
  logic [31:0]  m_axis_tdata_o;
  logic         m_axis_tlast_o, m_axis_tvalid_o, m_axis_tready_i;
  logic         psel, penable, pwrite, pready;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;

  key_chord_action_mapper DUT (.*);

  // mapper model state
  kcam_def_t   chord_table [32];
  bit          held_flag [32];
  logic [31:0] repeat_due [32];
  logic [5:0]  search_count;

  report_t     expected_reports [$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  logic [31:0] clock_ms = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [23:0] kbit(input int n);
    return 24'(1) << (n - 1);
  endfunction

  // held bit n-1 set = key n down; raw word is active low with bytes 0 and 2 swapped
  function automatic logic [23:0] key_word(input logic [23:0] held);
    logic [23:0] keys;
    keys = ~held;
    return {keys[7:0], keys[15:8], keys[23:16]};
  endfunction

  function automatic key_item_t scan_item(input logic [23:0] raw, input logic [31:0] now);
    key_item_t it;
    it.op = OP_SCAN;
    it.slot = 5'($urandom);
    it.k1 = 8'($urandom);
    it.k2 = 8'($urandom);
    it.k3 = 8'($urandom);
    it.mdf = 8'($urandom);
    it.kc = 8'($urandom);
    it.mode = 8'($urandom);
    it.raw = raw;
    it.now = now;
    return it;
  endfunction

  function automatic key_item_t def_item(input logic [4:0] slot, input logic [7:0] k1, k2, k3,
                                         input logic [7:0] mdf, kc, mode);
    key_item_t it;
    it = scan_item(24'($urandom), $urandom);
    it.op = OP_WRITE;
    it.slot = slot;
    it.k1 = k1;
    it.k2 = k2;
    it.k3 = k3;
    it.mdf = mdf;
    it.kc = kc;
    it.mode = mode;
    return it;
  endfunction

  function automatic plan_row_t fixed_row(input key_item_t it, input bit many, preq,
                                          input logic [4:0] pnum);
    plan_row_t r;
    r.it = it;
    r.typed = 1'b1;
    r.many = many;
    r.preq = preq;
    r.pnum = pnum;
    r.in_use = -1;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input key_item_t it, input int in_use);
    plan_row_t r;
    r = fixed_row(it, 1'b0, 1'b0, 5'd0);
    r.typed = 1'b0;
    r.in_use = in_use;
    return r;
  endfunction

  function automatic void push_action(input bit fire, input int slot, input kcam_def_t d);
    kcam_result_t r;
    r = '0;
    r.action_valid = fire;
    r.entry_number = 5'(slot);
    r.modifier_code = d.modifier;
    r.key_code = d.keycode;
    r.release_all = 1'b1;
    expected_reports.push_back('{r, 1'b0});
  endfunction

  function automatic void push_status(input bit many, preq, input logic [4:0] pnum);
    kcam_result_t r;
    r = '0;
    r.too_many_keys = many;
    r.profile_request_valid = preq;
    r.profile_number = pnum;
    expected_reports.push_back('{r, 1'b1});
  endfunction

  // Model of one accepted item: updates the mapper state and queues its reports.
  task automatic map_chord_item(input key_item_t it, output int produced);
    logic [23:0] keys;
    logic [7:0]  down [4];
    int          count, n;
    bit          fire, preq;
    kcam_def_t   d;
    produced = 1;
    if (it.op == OP_WRITE) begin
      chord_table[it.slot] = '{it.k1, it.k2, it.k3, it.mdf, it.kc, it.mode};
      push_status(1'b0, 1'b0, 5'd0);
      return;
    end
    keys = {it.raw[7:0], it.raw[15:8], it.raw[23:16]};
    down = '{default: 8'd0};
    count = 0;
    for (int i = 0; i < 24; i++) begin
      if (!keys[i] && count <= CHORD_SLOTS) begin
        if (count < CHORD_SLOTS) down[count] = 8'(i + 1);
        count++;
      end
    end
    if (count > CHORD_SLOTS) begin
      push_status(1'b1, 1'b0, 5'd0);
      return;
    end
    preq = count == CHORD_SLOTS && down[1] == PROFILE_KEY_A && down[2] == PROFILE_KEY_B &&
           down[3] == PROFILE_KEY_C;
    n = search_count > 32 ? 32 : int'(search_count);
    for (int i = 0; i < n; i++) begin
      d = chord_table[i];
      if (down[0] == 8'd0) begin
        // release: pending on-release entries fire, then all flags drop
        if (d.mode == MODE_RELEASE && held_flag[i]) begin
          push_action(1'b1, i, d);
          produced++;
        end
        held_flag[i] = 1'b0;
      end else if (d.k1 == down[0] && d.k2 == down[1] && d.k3 == down[2]) begin
        fire = 1'b0;
        if (d.mode == MODE_EVERY) begin
          fire = 1'b1;
        end else if (d.mode == MODE_ONCE) begin
          fire = !held_flag[i];
          held_flag[i] = 1'b1;
        end else if (d.mode == MODE_RELEASE) begin
          held_flag[i] = 1'b1;
        end else if (d.mode >= MODE_REPEAT_MIN && repeat_due[i] < it.now) begin
          repeat_due[i] = it.now + 32'(d.mode) * 32'(REPEAT_STEP_MS);
          fire = 1'b1;
        end
        push_action(fire, i, d);
        produced++;
      end
    end
    push_status(1'b0, preq, preq ? down[0][4:0] : 5'd0);
  endtask

  // Sender: bursts of items offered back to back, separated by random gaps.
  task automatic offer_item(input key_item_t it, output int produced);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tdata_i <= {3'b0, it.now, it.raw, it.mode, it.kc, it.mdf, it.k3, it.k2, it.k1,
                       it.slot};
    s_axis_tuser_i <= 1'(it.op);
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
    map_chord_item(it, produced);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write entries_in_use over APB (junk in the unused upper bits), then read it back.
  task automatic set_entries_in_use(input logic [5:0] value);
    logic [31:0] word;
    wait_idle();
    word = {26'($urandom), value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_ENTRIES_IN_USE, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    search_count = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(value)) begin
      errors++;
      if (errors <= 10) $display("register readback: expected %0d, got %h", value, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] advance_clock();
    if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(1, 300);
    return clock_ms;
  endfunction

  function automatic logic [23:0] random_keys(input int lo, hi);
    logic [23:0] held;
    int          m;
    held = '0;
    m = $urandom_range(lo, hi);
    while ($countones(held) < m) held |= kbit($urandom_range(1, 24));
    return held;
  endfunction

  function automatic key_item_t random_def(input logic [4:0] slot);
    key_item_t it;
    int        pick, k1, k2, k3;
    it = def_item(slot, 8'd0, 8'd0, 8'd0, 8'($urandom), 8'($urandom), MODE_EVERY);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.k1 = 8'($urandom);
      it.k2 = 8'($urandom);
      it.k3 = 8'($urandom);
    end else if (pick < 40 && slot != 0) begin
      // share a chord with a lower slot so one scan hits several entries
      k1 = $urandom_range(0, slot - 1);
      it.k1 = chord_table[k1].k1;
      it.k2 = chord_table[k1].k2;
      it.k3 = chord_table[k1].k3;
    end else begin
      k1 = $urandom_range(1, 22);
      k2 = $urandom_range(k1 + 1, 23);
      k3 = $urandom_range(k2 + 1, 24);
      pick = $urandom_range(0, 2);
      it.k1 = 8'(k1);
      it.k2 = pick == 0 ? 8'd0 : 8'(k2);
      it.k3 = pick != 2 ? 8'd0 : 8'(k3);
    end
    case ($urandom_range(0, 9))
      0, 1: it.mode = MODE_EVERY;
      2, 3: it.mode = MODE_ONCE;
      4, 5: it.mode = MODE_RELEASE;
      6, 7: it.mode = 8'($urandom_range(MODE_REPEAT_MIN, 40));
      8: it.mode = 8'($urandom_range(MODE_RELEASE + 1, MODE_REPEAT_MIN - 1));
      default: it.mode = 8'($urandom);
    endcase
    return it;
  endfunction

  // One gesture: a chord held over a few scans, usually followed by a release; or one definition write.
  task automatic run_gesture();
    logic [23:0] held;
    int          kind, n, s, top, produced;
    kcam_def_t   d;
    n = search_count > 32 ? 32 : int'(search_count);
    kind = $urandom_range(0, 99);
    held = random_keys(1, CHORD_SLOTS);
    if (kind < 60 && n > 0) begin
      d = chord_table[$urandom_range(0, n - 1)];
      top = d.k3 != 0 ? d.k3 : (d.k2 != 0 ? d.k2 : d.k1);
      if (d.k1 >= 1 && top <= 24 &&
          ((d.k2 == 0 && d.k3 == 0) || (d.k2 > d.k1 && (d.k3 == 0 || d.k3 > d.k2)))) begin
        held = kbit(d.k1);
        if (d.k2 != 0) held |= kbit(d.k2);
        if (d.k3 != 0) held |= kbit(d.k3);
        // an extra higher key keeps the first three unchanged
        if (top < 24 && $urandom_range(0, 4) == 0) held |= kbit($urandom_range(top + 1, 24));
      end
    end else if (kind < 70) begin
      held = kbit($urandom_range(1, PROFILE_KEY_A - 1)) | kbit(PROFILE_KEY_A) |
             kbit(PROFILE_KEY_B) | kbit(PROFILE_KEY_C);
    end else if (kind < 78) begin
      held = random_keys(CHORD_SLOTS + 1, 10);
    end else if (kind < 88) begin
      held = 24'($urandom);
    end else if (kind < 93) begin
      s = $urandom_range(0, 31);
      offer_item(random_def(5'(s)), produced);
      return;
    end
    repeat ($urandom_range(1, 4)) offer_item(scan_item(key_word(held), advance_clock()), produced);
    if ($urandom_range(0, 9) < 7) offer_item(scan_item(key_word('0), advance_clock()), produced);
  endtask

  // Receiver: stall pattern of its own, plus one long hold-off to back the block up.
  initial begin
    int style, span;
    bit held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && items_sent >= 200) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        held_off = 1'b1;
      end
      style = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      for (int c = 0; c < span; c++) begin
        case (style)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= $urandom_range(0, 99) < 60;
          2: m_axis_tready_i <= (c % 3) != 0;
          default: m_axis_tready_i <= $urandom_range(0, 99) < 15;
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic string describe(input kcam_result_t r, input logic l);
    return $sformatf("act %0b entry %0d mod %h key %h rel %0b many %0b prof %0b/%0d last %0b",
                     r.action_valid, r.entry_number, r.modifier_code, r.key_code,
                     r.release_all, r.too_many_keys, r.profile_request_valid,
                     r.profile_number, l);
  endfunction

  always @(posedge clk_i) begin : result_check
    kcam_result_t got;
    report_t      want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = kcam_result_t'(m_axis_tdata_o[29:0]);
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", describe(got, m_axis_tlast_o));
      end else begin
        want = expected_reports.pop_front();
        if (got.action_valid !== want.res.action_valid ||
            got.entry_number !== want.res.entry_number ||
            got.modifier_code !== want.res.modifier_code ||
            got.key_code !== want.res.key_code ||
            got.release_all !== want.res.release_all ||
            got.too_many_keys !== want.res.too_many_keys ||
            got.profile_request_valid !== want.res.profile_request_valid ||
            got.profile_number !== want.res.profile_number ||
            m_axis_tlast_o !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %s\n          actual   %s",
                     describe(want.res, want.last), describe(got, m_axis_tlast_o));
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin : stall_watch
    int quiet_cycles;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t directed [$];
    int        produced;
    int        plan [5];
    int        target;
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    search_count = '0;
    for (int i = 0; i < 32; i++) begin
      chord_table[i] = '0;
      held_flag[i] = 1'b0;
      repeat_due[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing searched yet: only status results
    directed.push_back(fixed_row(scan_item(key_word('0), 32'd0), 0, 0, 5'd0));
    directed.push_back(fixed_row(scan_item(key_word('1), 32'd1), 1, 0, 5'd0));
    directed.push_back(fixed_row(scan_item(key_word(kbit(1) | kbit(2) | kbit(3) | kbit(4) |
                                                    kbit(5)), 32'd2), 1, 0, 5'd0));
    directed.push_back(fixed_row(scan_item(key_word(kbit(5) | kbit(PROFILE_KEY_A) |
                       kbit(PROFILE_KEY_B) | kbit(PROFILE_KEY_C)), 32'd3), 0, 1, 5'd5));
    directed.push_back(fixed_row(scan_item(key_word(kbit(15) | kbit(PROFILE_KEY_A) |
                       kbit(PROFILE_KEY_B) | kbit(PROFILE_KEY_C)), 32'd4), 0, 1, 5'd15));
    // chord keys above the lowest one: not a profile request
    directed.push_back(fixed_row(scan_item(key_word(kbit(PROFILE_KEY_A) | kbit(PROFILE_KEY_B) |
                       kbit(PROFILE_KEY_C) | kbit(24)), 32'd5), 0, 0, 5'd0));
    directed.push_back(fixed_row(scan_item(key_word(kbit(24)), '1), 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd0, 8'd1, 8'd2, 8'd0, 8'h00, 8'hFF, MODE_EVERY),
                                 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd1, 8'd3, 8'd0, 8'd0, 8'hFF, 8'h00, MODE_ONCE),
                                 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd2, 8'd4, 8'd5, 8'd6, 8'h11, 8'h22, MODE_RELEASE),
                                 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd3, 8'd7, 8'd8, 8'd0, 8'h01, 8'h2C,
                                          MODE_REPEAT_MIN), 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd4, 8'd9, PROFILE_KEY_A, PROFILE_KEY_B, 8'h02,
                                          8'h04, MODE_NEVER_FIRES), 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd5, 8'd1, 8'd2, 8'd0, 8'h80, KEY_MOUSE_MOVE,
                                          MODE_REPEAT_MAX), 0, 0, 5'd0));
    directed.push_back(fixed_row(def_item(5'd31, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                                 0, 0, 5'd0));
    // six entries searched: every mode, release, repeat timing and wrap
    directed.push_back(checked_row(scan_item(key_word(kbit(1) | kbit(2)), 32'd100), 6));
    directed.push_back(checked_row(scan_item(key_word(kbit(1) | kbit(2)), 32'd200), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(3)), 32'd300), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(3)), 32'd301), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(4) | kbit(5) | kbit(6)), 32'd350),
                                   -1));
    directed.push_back(checked_row(scan_item(key_word('0), 32'd400), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(7) | kbit(8)), 32'd500), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(7) | kbit(8)), 32'd601), -1));
    // profile chord that also matches an entry
    directed.push_back(checked_row(scan_item(key_word(kbit(9) | kbit(PROFILE_KEY_A) |
                       kbit(PROFILE_KEY_B) | kbit(PROFILE_KEY_C)), 32'd700), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(1) | kbit(2)), '1), -1));
    directed.push_back(checked_row(scan_item(key_word(kbit(1) | kbit(2)), 32'd0), -1));

    foreach (directed[r]) begin
      if (directed[r].in_use >= 0) set_entries_in_use(6'(directed[r].in_use));
      offer_item(directed[r].it, produced);
      if (directed[r].typed) begin
        repeat (produced) void'(expected_reports.pop_back());
        push_status(directed[r].many, directed[r].preq, directed[r].pnum);
      end
    end

    for (int s = 0; s < 32; s++) offer_item(random_def(5'(s)), produced);
    plan = '{32, 63, $urandom_range(1, 31), 0, 33};
    foreach (plan[p]) begin
      set_entries_in_use(6'(plan[p]));
      target = items_sent + 70;
      while (items_sent < target) run_gesture();
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_reports.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
